// File: rtl/core/imf_pkg.sv
// Shared constants, types and the axis scaling function for the IMU frame parser.
// Used by every module under rtl/core; depends on nothing else.

package imf_pkg;

    // Frame layout
    localparam int FRAME_LEN  = 11;                 // total bytes, header included
    localparam int CNT_W      = $clog2(FRAME_LEN);  // holds 0 .. FRAME_LEN-1
    localparam int KEPT_BYTES = 7;                  // type byte plus three axis pairs
    localparam int KIDX_W     = $clog2(KEPT_BYTES);

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACC   = 8'h51;
    localparam logic [7:0] TYPE_RATE  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    // Result fields
    localparam int RAW_W  = 16;
    localparam int VAL_W  = 22;
    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_ACC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RATE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ANGLE = 2'd2;

    // Stream widths: result tdata is kind, x, y, z packed from bit 0, padded to bytes
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_FIELDS_W = KIND_W + 3 * VAL_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // Rate scaling: raw*2000/32768 reduces to raw*125/2048
    localparam int RATE_PROD_W = RAW_W + 8;
    localparam int RATE_SHIFT  = 11;
    localparam logic signed [RATE_PROD_W-1:0] RATE_MUL  = RATE_PROD_W'(125);
    localparam logic signed [RATE_PROD_W-1:0] RATE_BIAS = RATE_PROD_W'((1 << RATE_SHIFT) - 1);

    // Q13 degree scaling: raw*180/32768*8192 = raw*45, exact in VAL_W bits
    localparam logic signed [VAL_W-1:0] ANG_MUL = VAL_W'(45);

    // Decoded frame handed from the framer to the output stage
    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [RAW_W-1:0] raw_x;
        logic signed [RAW_W-1:0] raw_y;
        logic signed [RAW_W-1:0] raw_z;
    } t_frame;

    // Scale one raw axis sample; rate values truncate toward zero
    function automatic logic signed [VAL_W-1:0] scale_axis(
        input logic signed [RAW_W-1:0] raw,
        input logic                    rate
    );
        logic signed [RATE_PROD_W-1:0] prod;
        logic signed [RATE_PROD_W-1:0] adj;
        logic signed [VAL_W-1:0]       res;
        prod = RATE_PROD_W'(raw) * RATE_MUL;
        adj  = prod;
        if (prod < 0) begin
            adj = prod + RATE_BIAS;
        end
        if (rate) begin
            res = VAL_W'(adj >>> RATE_SHIFT);
        end else begin
            res = VAL_W'(raw) * ANG_MUL;
        end
        return res;
    endfunction

endpackage

// File: rtl/core/imf_in_reg.sv
// Input register stage: captures one received byte per item from the slave stream.
// Depends on imf_pkg.

module imf_in_reg
    import imf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    output logic                  o_rdy,
    input  logic [IN_TDATA_W-1:0] i_byte,
    output logic                  o_vld,
    input  logic                  i_rdy,
    output logic [IN_TDATA_W-1:0] o_byte
);

    logic                  r_vld;
    logic [IN_TDATA_W-1:0] r_byte;

    // Take a new byte whenever the register is empty or drains this cycle
    assign o_rdy  = !r_vld || i_rdy;
    assign o_vld  = r_vld;
    assign o_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    // Hold the byte until the framer consumes it
    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_byte <= i_byte;
        end
    end

endmodule

// File: rtl/core/imf_framer.sv
// Frame assembler: header hunt, byte counting, storage of the kept frame bytes and
// type decode. Emits one registered frame per complete frame of a known type.
// Depends on imf_pkg.

module imf_framer
    import imf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    output logic                  o_rdy,
    input  logic [IN_TDATA_W-1:0] i_byte,
    output logic                  o_vld,
    input  logic                  i_rdy,
    output t_frame                o_frame
);

    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [7:0]        r_bytes [KEPT_BYTES];
    logic [7:0]        n_bytes [KEPT_BYTES];
    logic [KIDX_W-1:0] wr_idx;
    logic              frame_end;
    logic              type_ok;
    logic              take;
    logic              emit;
    logic              r_frm_vld;
    t_frame            r_frm;
    t_frame            n_frm;

    assign o_rdy   = !r_frm_vld || i_rdy;
    assign take    = i_vld && o_rdy;
    assign emit    = take && frame_end && type_ok;
    assign o_vld   = r_frm_vld;
    assign o_frame = r_frm;
    assign wr_idx  = KIDX_W'(r_cnt - 1'b1);

    // Count bytes and merge the incoming one into the kept frame bytes
    always_comb begin
        n_cnt     = r_cnt;
        n_bytes   = r_bytes;
        frame_end = 1'b0;
        if (r_cnt == '0) begin
            if (i_byte == HDR_BYTE) begin
                n_cnt = CNT_W'(1);
            end
        end else begin
            // bytes past the last axis pair are counted only
            if (r_cnt <= CNT_W'(KEPT_BYTES)) begin
                n_bytes[wr_idx] = i_byte;
            end
            if (r_cnt == CNT_W'(FRAME_LEN - 1)) begin
                n_cnt     = '0;
                frame_end = 1'b1;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    // Decode the type byte and pick up the little-endian axis pairs
    always_comb begin
        type_ok    = 1'b1;
        n_frm.kind = KIND_ACC;
        unique case (n_bytes[0])
            TYPE_ACC:   n_frm.kind = KIND_ACC;
            TYPE_RATE:  n_frm.kind = KIND_RATE;
            TYPE_ANGLE: n_frm.kind = KIND_ANGLE;
            default:    type_ok    = 1'b0;
        endcase
        n_frm.raw_x = {n_bytes[2], n_bytes[1]};
        n_frm.raw_y = {n_bytes[4], n_bytes[3]};
        n_frm.raw_z = {n_bytes[6], n_bytes[5]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_frm_vld <= 1'b0;
        end else begin
            if (take) begin
                r_cnt <= n_cnt;
            end
            // drop the held frame once taken, then load a new one
            if (i_rdy) begin
                r_frm_vld <= 1'b0;
            end
            if (emit) begin
                r_frm_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_bytes <= n_bytes;
        end
        if (emit) begin
            r_frm <= n_frm;
        end
    end

endmodule

// File: rtl/core/imf_scale_out.sv
// Output stage: scales the three axis samples of a decoded frame and holds the
// packed result on the master stream. Depends on imf_pkg.

module imf_scale_out
    import imf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    output logic                   o_rdy,
    input  t_frame                 i_frame,
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [OUT_TDATA_W-1:0] o_tdata
);

    logic                    is_rate;
    logic signed [VAL_W-1:0] x_val;
    logic signed [VAL_W-1:0] y_val;
    logic signed [VAL_W-1:0] z_val;
    logic                    r_vld;
    logic [OUT_TDATA_W-1:0]  r_tdata;

    assign o_rdy    = !r_vld || i_tready;
    assign o_tvalid = r_vld;
    assign o_tdata  = r_tdata;

    // Scale each axis for the frame kind
    assign is_rate = (i_frame.kind == KIND_RATE);
    assign x_val   = scale_axis(i_frame.raw_x, is_rate);
    assign y_val   = scale_axis(i_frame.raw_y, is_rate);
    assign z_val   = scale_axis(i_frame.raw_z, is_rate);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    // Pack kind, x, y, z from bit 0 up
    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_tdata <= {{OUT_PAD_W{1'b0}}, z_val, y_val, x_val, i_frame.kind};
        end
    end

endmodule

// File: rtl/core/imu_frame_parser.sv
// Top level of the IMU serial frame parser: input register, framer, scaling output stage.
// Depends on imf_pkg, imf_in_reg, imf_framer and imf_scale_out.

// Takes one received serial byte per item on the slave stream and accepts a byte
// in every clock cycle as long as the result side keeps up. Bytes are dropped
// until the header 0x55; from there FRAME_LEN bytes form one frame, whose type
// byte selects the kind (0x51, 0x52 angular rate, 0x53 angle). A frame of a
// known type yields one result item with three axis values: whole deg/s
// (raw*2000/32768, truncated toward zero) for angular rate, Q13 degrees
// (raw*45) for the other two kinds. Frames of other types give no result and
// the checksum is not checked. The path is three register stages (input byte,
// decoded frame, scaled result); a frame's result is registered in the last
// of them once its last byte has passed the first two, and stalls on the master side
// back up through the stages one register at a time.

module imu_frame_parser
    import imf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [1:0] frame_kind, [23:2] x_value,
                                              // [45:24] y_value, [67:46] z_value
);

    logic                  byte_vld;
    logic                  byte_rdy;
    logic [IN_TDATA_W-1:0] byte_data;
    logic                  frm_vld;
    logic                  frm_rdy;
    t_frame                frm;

    imf_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_tvalid),
        .o_rdy   (s_tready),
        .i_byte  (s_tdata),
        .o_vld   (byte_vld),
        .i_rdy   (byte_rdy),
        .o_byte  (byte_data)
    );

    imf_framer u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (byte_vld),
        .o_rdy   (byte_rdy),
        .i_byte  (byte_data),
        .o_vld   (frm_vld),
        .i_rdy   (frm_rdy),
        .o_frame (frm)
    );

    imf_scale_out u_scale_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (frm_vld),
        .o_rdy    (frm_rdy),
        .i_frame  (frm),
        .o_tvalid (m_tvalid),
        .i_tready (m_tready),
        .o_tdata  (m_tdata)
    );

endmodule

// File: verif/tb_imu_frame_parser.sv
// Self-checking testbench for imu_frame_parser: serial bytes in, decoded axis frames out.
// Depends on imf_pkg for widths, header, type and kind codes; the expected results are
// worked out by a byte-level frame tracker kept in this file.

module tb_imu_frame_parser
    import imf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;  // cycles with no item moving before giving up
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 10;    // settle time after the last result
    localparam int RANDOM_ITEMS = 1560;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] z;
    } t_axis_result;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Frame tracker state
    int                     rx_count;
    logic [7:0]             rx_kept [KEPT_BYTES];
    t_axis_result           parsed_frames_q [$];

    int                     errors     = 0;
    int                     idle_count = 0;
    bit                     calm       = 1'b0;  // no random idling on either side while set
    int                     hold_seq   = 0;     // bump to request a receiver hold-off

    imu_frame_parser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Axis scaling: whole deg/s truncated toward zero for rate, Q13 degrees otherwise
    function automatic logic signed [VAL_W-1:0] scale_raw(input logic signed [15:0] raw,
                                                          input bit rate);
        int r;
        int v;
        r = raw;
        if (rate) begin
            v = (r * 2000) / 32768;
        end else begin
            v = r * 45;
        end
        return VAL_W'(v);
    endfunction

    // Advance the frame tracker by one accepted byte; queue a result on a known frame
    function automatic void track_rx_byte(input logic [7:0] b);
        t_axis_result res;
        bit           known;
        known = 1'b1;
        if (rx_count == 0) begin
            if (b == HDR_BYTE) begin
                rx_count = 1;
            end
            return;
        end
        if (rx_count - 1 < KEPT_BYTES) begin
            rx_kept[rx_count - 1] = b;
        end
        if (rx_count + 1 < FRAME_LEN) begin
            rx_count++;
            return;
        end
        rx_count = 0;
        case (rx_kept[0])
            TYPE_ACC:   res.kind = KIND_ACC;
            TYPE_RATE:  res.kind = KIND_RATE;
            TYPE_ANGLE: res.kind = KIND_ANGLE;
            default:    known = 1'b0;
        endcase
        if (!known) begin
            return;
        end
        res.x = scale_raw({rx_kept[2], rx_kept[1]}, res.kind == KIND_RATE);
        res.y = scale_raw({rx_kept[4], rx_kept[3]}, res.kind == KIND_RATE);
        res.z = scale_raw({rx_kept[6], rx_kept[5]}, res.kind == KIND_RATE);
        parsed_frames_q.push_back(res);
    endfunction

    // Offer one byte, idling first at random, and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge i_clk); while (!s_tready);
        track_rx_byte(b);
    endtask

    // Send a whole frame: header, type, three little-endian axis pairs, random tail
    task automatic send_frame(input logic [7:0] kind_byte, input logic [15:0] rx,
                              input logic [15:0] ry, input logic [15:0] rz);
        send_byte(HDR_BYTE);
        send_byte(kind_byte);
        send_byte(rx[7:0]);
        send_byte(rx[15:8]);
        send_byte(ry[7:0]);
        send_byte(ry[15:8]);
        send_byte(rz[7:0]);
        send_byte(rz[15:8]);
        for (int i = 8; i < FRAME_LEN; i++) begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    function automatic logic [15:0] pick_raw();
        logic [15:0] corners [6];
        corners = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0055};
        if ($urandom_range(7) == 0) begin
            return corners[$urandom_range(5)];
        end
        return 16'($urandom_range(16'hFFFF));
    endfunction

    // Drive m_tready: random idling, calm stretches, and a counted hold-off on request
    always @(posedge i_clk) begin : drive_ready
        int hold_seen;
        int hold_left;
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 33);
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare each accepted result with the oldest expected frame
    always @(posedge i_clk) begin : check_results
        t_axis_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (parsed_frames_q.size() == 0) begin
                $display("%0t: unexpected result, expected nothing, actual %h", $time, m_tdata);
                errors++;
            end else begin
                want = parsed_frames_q.pop_front();
                check_field("frame_kind", want.kind, m_tdata[KIND_W-1:0]);
                check_field("x_value", want.x, $signed(m_tdata[KIND_W +: VAL_W]));
                check_field("y_value", want.y, $signed(m_tdata[KIND_W + VAL_W +: VAL_W]));
                check_field("z_value", want.z, $signed(m_tdata[KIND_W + 2*VAL_W +: VAL_W]));
            end
        end
    end

    // Watchdog: end the run when no item moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
        end
        if (idle_count >= IDLE_LIMIT) begin
            $display("tb_imu_frame_parser: done, errors");
            $finish;
        end
    end

    task automatic test_reset();
        rx_count = 0;
        foreach (rx_kept[i]) rx_kept[i] = 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    // Extremes for acceleration and rate, idle noise, header inside a frame, unknown type
    task automatic test_directed();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h54);
        send_frame(TYPE_ACC, 16'h7FFF, 16'h8000, 16'h0000);
        send_frame(TYPE_RATE, 16'hFFFF, 16'h7FFF, 16'h8000);
        send_frame(TYPE_ANGLE, 16'h5555, 16'h0055, 16'hFF55);
        send_frame(8'h50, 16'h1234, 16'h8001, 16'h7FFE);
        send_frame(TYPE_RATE, 16'h0011, 16'hFFEF, 16'hFFF0);
    endtask

    // Hold the receiver off while frames keep coming, so the block fills and stalls
    task automatic test_backpressure();
        calm = 1'b1;
        hold_seq++;
        repeat (4) begin
            send_frame(TYPE_ANGLE, pick_raw(), pick_raw(), pick_raw());
        end
        calm = 1'b0;
    endtask

    // Mostly well-formed frames with random content, plus noise and cut-off frames
    task automatic test_random();
        int sent;
        int frames;
        int pick;
        logic [7:0] kind_byte;
        sent   = 0;
        frames = 0;
        while (sent < RANDOM_ITEMS) begin
            calm = (frames >= 40 && frames < 70);
            pick = $urandom_range(99);
            if (pick < 80) begin
                kind_byte = (pick < 27) ? TYPE_ACC : (pick < 54) ? TYPE_RATE : TYPE_ANGLE;
            end else if (pick < 90) begin
                kind_byte = 8'($urandom_range(255));
            end else begin
                kind_byte = HDR_BYTE;
            end
            if ($urandom_range(99) < 5) begin
                // cut-off frame: header and a few bytes, the next frame runs into it
                send_byte(HDR_BYTE);
                repeat ($urandom_range(1, FRAME_LEN - 2)) send_byte(8'($urandom_range(255)));
            end else begin
                send_frame(kind_byte, pick_raw(), pick_raw(), pick_raw());
                sent += FRAME_LEN;
            end
            // idle noise between frames is dropped and not counted
            if ($urandom_range(99) < 30) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
            end
            frames++;
        end
        calm = 1'b0;
    endtask

    initial begin
        test_reset();
        test_directed();
        test_backpressure();
        test_random();
        s_tvalid <= 1'b0;
        while (parsed_frames_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_imu_frame_parser: done, clean");
        end else begin
            $display("tb_imu_frame_parser: done, errors");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/imf_pkg.sv
rtl/core/imf_in_reg.sv
rtl/core/imf_framer.sv
rtl/core/imf_scale_out.sv
rtl/core/imu_frame_parser.sv
verif/tb_imu_frame_parser.sv
